// File: hw/rtl/mc3v_pkg.sv
// ----------------------------------------------------------------------------
// mc3v_pkg
// types, constants and saturation helpers for the masked 3d convolution unit
// ----------------------------------------------------------------------------
package mc3v_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int SMP_W      = 16;
  localparam int POS_W      = 12;
  localparam int ACC_W      = 48;
  localparam int WACC_W     = 32;
  localparam int ALU_W      = 64;
  localparam int S_DATA_W   = 88;
  localparam int M_DATA_W   = 48;
  localparam int M_USER_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SIZE_IN_W  = 11;
  localparam int DIV_STEPS  = ACC_W + FRAC_BITS;

  localparam int USER_CPAD  = 0;
  localparam int USER_NOWGT = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PADDING   = 3'd0,
    CFG_NORMALIZE = 3'd1,
    CFG_SIZE_X    = 3'd2,
    CFG_SIZE_Y    = 3'd3,
    CFG_SIZE_Z    = 3'd4
  } cfg_idx_t;

  // clamp a 64-bit sum to the 48-bit signed range
  function automatic logic [ACC_W-1:0] sat_acc(input logic [ALU_W-1:0] v);
    logic ovf;
    ovf = !((&v[ALU_W-1:ACC_W-1]) || !(|v[ALU_W-1:ACC_W-1]));
    if (!ovf) sat_acc = v[ACC_W-1:0];
    else if (v[ALU_W-1]) sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
    else sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

  // clamp a 64-bit sum to the 32-bit signed range
  function automatic logic [WACC_W-1:0] sat_wacc(input logic [ALU_W-1:0] v);
    logic ovf;
    ovf = !((&v[ALU_W-1:WACC_W-1]) || !(|v[ALU_W-1:WACC_W-1]));
    if (!ovf) sat_wacc = v[WACC_W-1:0];
    else if (v[ALU_W-1]) sat_wacc = {1'b1, {(WACC_W-1){1'b0}}};
    else sat_wacc = {1'b0, {(WACC_W-1){1'b1}}};
  endfunction

endpackage

// File: hw/rtl/masked_convolution_3d_voxel_unit.sv
// ----------------------------------------------------------------------------
// masked_convolution_3d_voxel_unit
// one output voxel of a padding-aware 3d convolution, fed one window sample
// per word, with a shared 64-bit adder for accumulation and division
// ----------------------------------------------------------------------------
// a sample word is taken only in idle and passes multiply, add data, add weight; a skipped one only multiply
// last word: then finish, done and output, with abs, the 62-step divide and sign before done when the divide runs
// throughput is set by the sequencer reusing one 64-bit adder for the accumulate, abs, divide and sign steps
// reset: sync active high, clears accumulators, config to defaults, no output
module masked_convolution_3d_voxel_unit
  import mc3v_pkg::*;
#(
  parameter int MAX_DIM = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // sample, weight, pos_x, pos_y, pos_z, center_value, 4 unused bits
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // result
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  // centre_padded, no_weight
  output logic [M_USER_W-1:0]   m_axis_tuser
);

  localparam int DIM_BITS = $clog2(MAX_DIM + 1);
  localparam int CW       = ((DIM_BITS > SIZE_IN_W) ? DIM_BITS : SIZE_IN_W) + 1;
  localparam logic [CW-1:0] DIM_MAX  = CW'(MAX_DIM);
  localparam logic [CW-1:0] SIZE_RST = CW'((MAX_DIM < 1024) ? MAX_DIM : 1024);
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam int REM_W = WACC_W - 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ADD_DATA, ST_ADD_WGT, ST_FIN,
    ST_ABS, ST_DIV, ST_SIGN, ST_DONE
  } state_t;

  state_t state;

  logic signed [SMP_W-1:0]  padding;
  logic                     normalize;
  logic [CW-1:0]            size_x, size_y, size_z;

  logic signed [SMP_W-1:0]  smp, wgt, ctr;
  logic [POS_W-1:0]         px, py, pz;
  logic                     lst;

  logic signed [WACC_W-1:0] prod;
  logic [ACC_W-1:0]         weighted_acc;
  logic [WACC_W-1:0]        weight_acc;
  logic [DIV_STEPS-1:0]     quo;
  logic [REM_W-1:0]         rem;
  logic [CNT_W-1:0]         cnt;
  logic                     neg;
  logic [ACC_W-1:0]         res;
  logic                     cpad, nowgt;

  logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
  logic             alu_cin;
  logic [REM_W:0]   rem_sh;
  logic [ALU_W-1:0] num;
  logic [CW-1:0]    cfg_size;
  logic             in_x, in_y, in_z, used, out_free, wsum_pos;

  assign rem_sh   = {rem, quo[DIV_STEPS-1]};
  assign num      = {{(ALU_W-ACC_W-FRAC_BITS){weighted_acc[ACC_W-1]}}, weighted_acc,
                     {FRAC_BITS{1'b0}}};
  assign cfg_size = ({{(CW-SIZE_IN_W){1'b0}}, cfg_data[SIZE_IN_W-1:0]} > DIM_MAX) ?
                    DIM_MAX : {{(CW-SIZE_IN_W){1'b0}}, cfg_data[SIZE_IN_W-1:0]};

  assign in_x = !px[POS_W-1] && ({{(CW-POS_W+1){1'b0}}, px[POS_W-2:0]} < size_x);
  assign in_y = !py[POS_W-1] && ({{(CW-POS_W+1){1'b0}}, py[POS_W-2:0]} < size_y);
  assign in_z = !pz[POS_W-1] && ({{(CW-POS_W+1){1'b0}}, pz[POS_W-2:0]} < size_z);
  assign used = in_x && in_y && in_z && (smp > padding);

  assign wsum_pos = !weight_acc[WACC_W-1] && (weight_acc != '0);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // shared adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    unique case (state)
      ST_ADD_DATA: begin
        alu_a = {{(ALU_W-ACC_W){weighted_acc[ACC_W-1]}}, weighted_acc};
        alu_b = {{(ALU_W-WACC_W){prod[WACC_W-1]}}, prod};
      end
      ST_ADD_WGT: begin
        alu_a = {{(ALU_W-WACC_W){weight_acc[WACC_W-1]}}, weight_acc};
        alu_b = {{(ALU_W-SMP_W){wgt[SMP_W-1]}}, wgt};
      end
      ST_ABS: begin
        alu_a   = ~num;
        alu_cin = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {{(ALU_W-REM_W-1){1'b0}}, rem_sh};
        alu_b   = ~{{(ALU_W-REM_W){1'b0}}, weight_acc[REM_W-1:0]};
        alu_cin = 1'b1;
      end
      ST_SIGN: begin
        alu_a   = neg ? ~{{(ALU_W-DIV_STEPS){1'b0}}, quo} : {{(ALU_W-DIV_STEPS){1'b0}}, quo};
        alu_cin = neg;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b + {{(ALU_W-1){1'b0}}, alu_cin};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      padding       <= '0;
      normalize     <= 1'b1;
      size_x        <= SIZE_RST;
      size_y        <= SIZE_RST;
      size_z        <= SIZE_RST;
      weighted_acc  <= '0;
      weight_acc    <= '0;
      m_axis_tvalid <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_PADDING:   padding   <= cfg_data;
          CFG_NORMALIZE: normalize <= cfg_data[0];
          CFG_SIZE_X:    size_x    <= cfg_size;
          CFG_SIZE_Y:    size_y    <= cfg_size;
          CFG_SIZE_Z:    size_z    <= cfg_size;
          default: ;
        endcase
      end

      if (state == ST_DONE && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            smp   <= s_axis_tdata[15:0];
            wgt   <= s_axis_tdata[31:16];
            px    <= s_axis_tdata[43:32];
            py    <= s_axis_tdata[55:44];
            pz    <= s_axis_tdata[67:56];
            ctr   <= s_axis_tdata[83:68];
            lst   <= s_axis_tlast;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod <= WACC_W'(smp) * WACC_W'(wgt);
          if (used) state <= ST_ADD_DATA;
          else if (lst) state <= ST_FIN;
          else state <= ST_IDLE;
        end
        ST_ADD_DATA: begin
          weighted_acc <= sat_acc(alu_sum);
          state        <= ST_ADD_WGT;
        end
        ST_ADD_WGT: begin
          weight_acc <= sat_wacc(alu_sum);
          state      <= lst ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          if (ctr <= padding) begin
            res   <= {{(ACC_W-SMP_W-FRAC_BITS){padding[SMP_W-1]}}, padding,
                      {FRAC_BITS{1'b0}}};
            cpad  <= 1'b1;
            nowgt <= 1'b0;
            state <= ST_DONE;
          end else if (normalize) begin
            cpad <= 1'b0;
            if (wsum_pos) begin
              neg   <= weighted_acc[ACC_W-1];
              nowgt <= 1'b0;
              state <= ST_ABS;
            end else begin
              res   <= '0;
              nowgt <= 1'b1;
              state <= ST_DONE;
            end
          end else begin
            res   <= weighted_acc;
            cpad  <= 1'b0;
            nowgt <= 1'b0;
            state <= ST_DONE;
          end
        end
        ST_ABS: begin
          quo   <= neg ? alu_sum[DIV_STEPS-1:0] : num[DIV_STEPS-1:0];
          rem   <= '0;
          cnt   <= CNT_W'(DIV_STEPS);
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem   <= alu_sum[ALU_W-1] ? rem_sh[REM_W-1:0] : alu_sum[REM_W-1:0];
          quo   <= {quo[DIV_STEPS-2:0], !alu_sum[ALU_W-1]};
          cnt   <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) state <= ST_SIGN;
        end
        ST_SIGN: begin
          res   <= sat_acc(alu_sum);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tdata  <= res;
            m_axis_tuser  <= {nowgt, cpad};
            weighted_acc  <= '0;
            weight_acc    <= '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt != '0)
    else $error("divide step with empty counter");

  a_div_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> wsum_pos)
    else $error("divide with non-positive weight sum");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DONE))
    else $error("result word raised outside done step");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[USER_CPAD] && m_axis_tuser[USER_NOWGT]))
    else $error("both result flags set");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> weighted_acc == '0 && weight_acc == '0)
    else $error("accumulators not cleared after result");
`endif

endmodule
